// File: hw/rtl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg: shared types and codes of the bully leader election node
// Message codes, item operations, config register indexes, datapath actions
// and the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ble_pkg;

    // item operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MSG   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // message codes
    localparam logic [2:0] MSG_AYA     = 3'd0;
    localparam logic [2:0] MSG_ALIVE   = 3'd1;
    localparam logic [2:0] MSG_ELECT   = 3'd2;
    localparam logic [2:0] MSG_ACK     = 3'd3;
    localparam logic [2:0] MSG_JOIN    = 3'd4;
    localparam logic [2:0] MSG_WELCOME = 3'd5;
    localparam logic [2:0] MSG_LEAVE   = 3'd6;
    localparam logic [2:0] MSG_COORD   = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_MY_ID     = 3'd0;
    localparam logic [2:0] REG_ALIVE_INT = 3'd1;
    localparam logic [2:0] REG_ALIVE_TO  = 3'd2;
    localparam logic [2:0] REG_ELECT_TO  = 3'd3;
    localparam logic [2:0] REG_ANN_TO    = 3'd4;

    localparam logic [63:0] BCAST_ID = 64'h0000_0000_FFFF_FFFF;

    typedef logic [4:0] t_act;

    localparam t_act ACT_NONE     = 5'd0;
    localparam t_act ACT_LOAD     = 5'd1;
    localparam t_act ACT_DISPATCH = 5'd2;
    localparam t_act ACT_SCAN_RD  = 5'd3;
    localparam t_act ACT_FIND     = 5'd4;
    localparam t_act ACT_ADD      = 5'd5;
    localparam t_act ACT_LAST_RD  = 5'd6;
    localparam t_act ACT_MOVE_WR  = 5'd7;
    localparam t_act ACT_SE_BEGIN = 5'd8;
    localparam t_act ACT_SE_EMIT  = 5'd9;
    localparam t_act ACT_SE_END   = 5'd10;
    localparam t_act ACT_WELCOME  = 5'd11;
    localparam t_act ACT_WIN      = 5'd12;
    localparam t_act ACT_PRUNE    = 5'd13;
    localparam t_act ACT_ANN      = 5'd14;
    localparam t_act ACT_IDX0     = 5'd15;
    localparam t_act ACT_PROBE    = 5'd16;
    localparam t_act ACT_FLUSH    = 5'd17;

    typedef struct packed {
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] code;
        logic       addressed;
        logic       from_is_my;
        logic       my_lt_from;
        logic       from_lt_my;
        logic       from_is_coord;
        logic       electing;
        logic       coord_alive;
        logic       ed_reached;
        logic       ad_reached;
        logic       idx_lt_cnt;
        logic       hit;
        logic       rd_lt_my;
        logic       any;
    } t_stat;

endpackage

// File: hw/rtl/bully_leader_election.sv
// ----------------------------------------------------------------------------
// bully_leader_election: one node of a bully leader election group
// Takes ticks, received messages and a start command, keeps the member
// table and election state, and sends the messages that result.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low; busy stays high until
// every message of the item but the last is sent. Each message appears for
// one cycle on o_strobe and cannot be held off; the last one of an item
// carries o_last, and it shows in the first cycle busy is low again.
// The node takes no new item until busy is low again. Table scans lengthen
// an item: a lookup for join, welcome and leave, one pass to send elect,
// and on a win a prune pass and an announce pass; each entry removed also
// takes a read of the last entry and a move into its place. The table
// memory has a single read port with registered read data, so scans visit
// one entry at a time. The worst case is a leave from the coordinator that
// ends in a win. Items that send nothing still take the full check sequence.
// Config writes (i_cfg_we/i_cfg_idx/i_cfg_data) land at once and are meant
// for idle periods only; index 0 my_id, 1 probe interval, 2 alive timeout,
// 3 elect timeout, 4 announce timeout. The table needs no clearing pass.
// ----------------------------------------------------------------------------
module bully_leader_election import ble_pkg::*; #(
    parameter int GROUP_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_msg_code,
    input  logic [63:0] i_sender_id,
    input  logic [63:0] i_target_id,
    input  logic [31:0] i_election_tag,
    output logic        o_strobe,
    output logic [2:0]  o_send_code,
    output logic [63:0] o_dest_id,
    output logic [31:0] o_send_tag,
    output logic        o_last
);
    t_cmd  cmd;
    t_stat stat;

    ble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ble_dp #(.GROUP_MAX(GROUP_MAX)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_msg_code     (i_msg_code),
        .i_sender_id    (i_sender_id),
        .i_target_id    (i_target_id),
        .i_election_tag (i_election_tag),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_send_code    (o_send_code),
        .o_dest_id      (o_dest_id),
        .o_send_tag     (o_send_tag),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the node busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // once idle, only the final beat of an item can still show
    a_idle_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_last) else $error("non-final beat while idle");

    // the final beat ends the item's output
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe) else $error("beat after last");
`endif
endmodule

// File: hw/rtl/ble_ram.sv
// ----------------------------------------------------------------------------
// ble_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ble_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/ble_dp.sv
// ----------------------------------------------------------------------------
// ble_dp: datapath of the election node
// Config, node state, member table, scan index and the result stage
// (one pending beat, so the final beat of an item can carry last).
// ----------------------------------------------------------------------------
module ble_dp import ble_pkg::*; #(
    parameter int GROUP_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_msg_code,
    input  logic [63:0] i_sender_id,
    input  logic [63:0] i_target_id,
    input  logic [31:0] i_election_tag,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_strobe,
    output logic [2:0]  o_send_code,
    output logic [63:0] o_dest_id,
    output logic [31:0] o_send_tag,
    output logic        o_last
);
    localparam int CW  = $clog2(GROUP_MAX + 1);
    localparam int AW  = $clog2(GROUP_MAX);
    localparam int CAP = 2 * GROUP_MAX + 2;
    localparam int EW  = $clog2(CAP + 1);

    logic [63:0] r_my_id;
    logic [7:0]  r_ai, r_at, r_et, r_ant;
    logic [1:0]  r_op;
    logic [2:0]  r_code;
    logic [63:0] r_from, r_target;
    logic [31:0] r_tag;
    logic [CW-1:0] r_count, r_idx;
    logic [AW-1:0] r_pos;
    logic [63:0] r_coord;
    logic        r_calive, r_elect, r_hit, r_any;
    logic [31:0] r_en, r_ed, r_ad, r_pt, r_now;
    logic        r_pv;
    logic [2:0]  r_p_code;
    logic [63:0] r_p_dest;
    logic [31:0] r_p_tag;
    logic [EW-1:0] r_ecnt;
    logic        r_o_valid, r_o_last;
    logic [2:0]  r_o_code;
    logic [63:0] r_o_dest;
    logic [31:0] r_o_tag;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, rdata;
    logic [CW-1:0] cnt_m1;
    logic          addressed, pt_reached;
    logic [31:0]   ed_diff, ad_diff, pt_diff;
    logic          e_req;
    logic [2:0]    e_code;
    logic [63:0]   e_dest;
    logic [31:0]   e_tag;

    assign cnt_m1     = r_count - 1'b1;
    assign addressed  = (r_target == BCAST_ID) || (r_target == r_my_id);
    // a deadline is reached once now has caught up with it (mod 2^32)
    assign ed_diff    = r_now - r_ed;
    assign ad_diff    = r_now - r_ad;
    assign pt_diff    = r_now - r_pt;
    assign pt_reached = ~pt_diff[31];

    ble_ram #(.WIDTH(64), .DEPTH(GROUP_MAX)) u_tab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        ram_raddr = (i_cmd.act == ACT_LAST_RD) ? cnt_m1[AW-1:0] : r_idx[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = rdata;
        if (i_cmd.act == ACT_ADD) begin
            ram_we    = !r_hit && (r_count < CW'(GROUP_MAX));
            ram_waddr = r_count[AW-1:0];
            ram_wdata = r_from;
        end else if (i_cmd.act == ACT_MOVE_WR) begin
            ram_we = 1'b1;
        end
    end

    // result request of this cycle
    always_comb begin
        e_req  = 1'b0;
        e_code = MSG_AYA;
        e_dest = rdata;
        e_tag  = '0;
        case (i_cmd.act)
            ACT_DISPATCH: begin
                if (r_op == OP_START) begin
                    e_req  = 1'b1;
                    e_code = MSG_JOIN;
                    e_dest = BCAST_ID;
                end else if (r_op == OP_MSG && addressed) begin
                    e_dest = r_from;
                    e_tag  = r_tag;
                    if (r_code == MSG_AYA) begin
                        e_req  = 1'b1;
                        e_code = MSG_ALIVE;
                    end else if (r_code == MSG_ELECT) begin
                        e_req  = 1'b1;
                        e_code = MSG_ACK;
                    end
                end
            end
            ACT_SE_EMIT: begin
                e_req  = rdata < r_my_id;
                e_code = MSG_ELECT;
                e_tag  = r_en;
            end
            ACT_WELCOME: begin
                e_req  = 1'b1;
                e_code = MSG_WELCOME;
                e_dest = r_from;
                e_tag  = r_tag;
            end
            ACT_ANN: begin
                e_req  = 1'b1;
                e_code = MSG_COORD;
            end
            ACT_PROBE: begin
                e_req  = r_calive && pt_reached && (r_my_id != r_coord) && !r_elect;
                e_code = MSG_AYA;
                e_dest = r_coord;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id   <= '0;
            r_ai      <= 8'd10;
            r_at      <= 8'd2;
            r_et      <= 8'd2;
            r_ant     <= 8'd10;
            r_count   <= '0;
            r_coord   <= '0;
            r_calive  <= 1'b0;
            r_elect   <= 1'b0;
            r_en      <= '0;
            r_ed      <= '0;
            r_ad      <= '0;
            r_pt      <= '0;
            r_now     <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_any     <= 1'b0;
            r_pv      <= 1'b0;
            r_ecnt    <= '0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MY_ID:     r_my_id <= i_cfg_data;
                    REG_ALIVE_INT: r_ai    <= i_cfg_data[7:0];
                    REG_ALIVE_TO:  r_at    <= i_cfg_data[7:0];
                    REG_ELECT_TO:  r_et    <= i_cfg_data[7:0];
                    REG_ANN_TO:    r_ant   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // pending beat goes out when a newer one is taken below the item's cap or at the flush
            r_o_valid <= r_pv && ((e_req && r_ecnt < EW'(CAP)) || i_cmd.act == ACT_FLUSH);
            if (e_req && r_ecnt < EW'(CAP)) begin
                if (r_pv) begin
                    r_o_last  <= 1'b0;
                    r_o_code  <= r_p_code;
                    r_o_dest  <= r_p_dest;
                    r_o_tag   <= r_p_tag;
                end
                r_pv     <= 1'b1;
                r_p_code <= e_code;
                r_p_dest <= e_dest;
                r_p_tag  <= e_tag;
                r_ecnt   <= r_ecnt + 1'b1;
            end

            case (i_cmd.act)
                ACT_LOAD: begin
                    r_op     <= i_op;
                    r_code   <= i_msg_code;
                    r_from   <= i_sender_id;
                    r_target <= i_target_id;
                    r_tag    <= i_election_tag;
                    r_ecnt   <= '0;
                end
                ACT_DISPATCH: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                    if (r_op == OP_TICK) begin
                        r_now <= r_now + 1'b1;
                    end else if (r_op == OP_START) begin
                        r_ad <= r_now + 32'(r_at);
                    end else if (r_op == OP_MSG && addressed) begin
                        case (r_code)
                            MSG_ALIVE: if (r_from == r_coord) r_calive <= 1'b1;
                            MSG_ACK: begin
                                if (r_tag == r_en) begin
                                    r_elect <= 1'b0;
                                    r_ad    <= r_now + 32'(r_ant);
                                end
                            end
                            MSG_COORD: begin
                                r_coord  <= r_from;
                                r_calive <= 1'b1;
                                r_pt     <= r_now + 32'(r_ai);
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_FIND: begin
                    if (rdata == r_from) begin
                        r_hit <= 1'b1;
                        r_pos <= r_idx[AW-1:0];
                    end
                    r_idx <= r_idx + 1'b1;
                end
                ACT_ADD: begin
                    if (!r_hit && r_count < CW'(GROUP_MAX)) r_count <= r_count + 1'b1;
                end
                ACT_LAST_RD: r_count <= cnt_m1;
                ACT_SE_BEGIN: begin
                    r_elect  <= 1'b1;
                    r_calive <= 1'b0;
                    r_en     <= r_en + 1'b1;
                    r_any    <= 1'b0;
                    r_idx    <= '0;
                end
                ACT_SE_EMIT: begin
                    if (rdata < r_my_id) r_any <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                end
                ACT_SE_END: r_ed <= r_any ? r_now + 32'(r_et) : r_now;
                ACT_WELCOME: begin
                    if (r_elect && r_from < r_my_id) r_elect <= 1'b0;
                end
                ACT_WIN: begin
                    r_coord  <= r_my_id;
                    r_calive <= 1'b1;
                    r_pt     <= r_now + 32'(r_ai);
                    r_elect  <= 1'b0;
                    r_idx    <= '0;
                end
                ACT_PRUNE: begin
                    r_pos <= r_idx[AW-1:0];
                    if (!(rdata < r_my_id)) r_idx <= r_idx + 1'b1;
                end
                ACT_ANN: r_idx <= r_idx + 1'b1;
                ACT_IDX0: r_idx <= '0;
                ACT_PROBE: begin
                    if (r_calive && pt_reached) begin
                        if (r_my_id != r_coord && !r_elect) r_calive <= 1'b0;
                        r_ad <= r_now + 32'(r_at);
                        r_pt <= r_now + 32'(r_ai);
                    end
                end
                ACT_FLUSH: begin
                    if (r_pv) begin
                        r_o_last  <= 1'b1;
                        r_o_code  <= r_p_code;
                        r_o_dest  <= r_p_dest;
                        r_o_tag   <= r_p_tag;
                        r_pv      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.op            = r_op;
        o_stat.code          = r_code;
        o_stat.addressed     = addressed;
        o_stat.from_is_my    = r_from == r_my_id;
        o_stat.my_lt_from    = r_my_id < r_from;
        o_stat.from_lt_my    = r_from < r_my_id;
        o_stat.from_is_coord = r_from == r_coord;
        o_stat.electing      = r_elect;
        o_stat.coord_alive   = r_calive;
        o_stat.ed_reached    = ~ed_diff[31];
        o_stat.ad_reached    = ~ad_diff[31];
        o_stat.idx_lt_cnt    = r_idx < r_count;
        o_stat.hit           = r_hit;
        o_stat.rd_lt_my      = rdata < r_my_id;
        o_stat.any           = r_any;
    end

    assign o_strobe    = r_o_valid;
    assign o_send_code = r_o_code;
    assign o_dest_id   = r_o_dest;
    assign o_send_tag  = r_o_tag;
    assign o_last      = r_o_last;
endmodule

// File: hw/rtl/ble_ctrl.sv
// ----------------------------------------------------------------------------
// ble_ctrl: sequencer of the election node
// Walks one item through dispatch, table scans, election and the
// end-of-item deadline checks, issuing at most one datapath action per cycle.
// ----------------------------------------------------------------------------
module ble_ctrl import ble_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_F_RD   = 5'd2;
    localparam logic [4:0] S_F_CHK  = 5'd3;
    localparam logic [4:0] S_F_DONE = 5'd4;
    localparam logic [4:0] S_JOIN2  = 5'd5;
    localparam logic [4:0] S_R_LAST = 5'd6;
    localparam logic [4:0] S_R_MV   = 5'd7;
    localparam logic [4:0] S_LEAVE2 = 5'd8;
    localparam logic [4:0] S_SE     = 5'd9;
    localparam logic [4:0] S_SE_RD  = 5'd10;
    localparam logic [4:0] S_SE_EV  = 5'd11;
    localparam logic [4:0] S_WIN    = 5'd12;
    localparam logic [4:0] S_P_RD   = 5'd13;
    localparam logic [4:0] S_P_EV   = 5'd14;
    localparam logic [4:0] S_P_LAST = 5'd15;
    localparam logic [4:0] S_P_MV   = 5'd16;
    localparam logic [4:0] S_A_RD   = 5'd17;
    localparam logic [4:0] S_A_EV   = 5'd18;
    localparam logic [4:0] S_CHK_E  = 5'd19;
    localparam logic [4:0] S_CHK_A  = 5'd20;
    localparam logic [4:0] S_CHK_P  = 5'd21;
    localparam logic [4:0] S_FLUSH  = 5'd22;

    localparam logic [1:0] MODE_WEL  = 2'd0;
    localparam logic [1:0] MODE_JOIN = 2'd1;
    localparam logic [1:0] MODE_REM  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [4:0] r_after, n_after;   // where an election or win returns to
    logic [1:0] r_mode, n_mode;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_mode    = r_mode;
        o_cmd.act = ACT_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.act = ACT_LOAD;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.act = ACT_DISPATCH;
                n_state   = S_CHK_E;
                n_after   = S_CHK_E;
                if (i_stat.op == OP_MSG && i_stat.addressed) begin
                    case (i_stat.code)
                        MSG_ELECT: n_state = S_SE;
                        MSG_COORD: if (i_stat.my_lt_from) n_state = S_SE;
                        MSG_JOIN: begin
                            if (!i_stat.from_is_my) begin
                                n_mode  = MODE_JOIN;
                                n_state = S_F_RD;
                            end
                        end
                        MSG_WELCOME: begin
                            n_mode  = MODE_WEL;
                            n_state = S_F_RD;
                        end
                        MSG_LEAVE: begin
                            n_mode  = MODE_REM;
                            n_state = S_F_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_F_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.act = ACT_SCAN_RD;
                    n_state   = S_F_CHK;
                end else begin
                    n_state = S_F_DONE;
                end
            end
            S_F_CHK: begin
                o_cmd.act = ACT_FIND;
                n_state   = i_stat.rd_lt_my ? S_F_RD : S_F_RD;
                if (i_stat.hit) n_state = S_F_DONE;
            end
            S_F_DONE: begin
                if (r_mode == MODE_REM) begin
                    n_state = i_stat.hit ? S_R_LAST : S_LEAVE2;
                end else begin
                    o_cmd.act = ACT_ADD;
                    n_state   = (r_mode == MODE_JOIN) ? S_JOIN2 : S_CHK_E;
                end
            end
            S_JOIN2: begin
                o_cmd.act = ACT_WELCOME;
                n_state   = (i_stat.electing && i_stat.from_lt_my) ? S_SE : S_CHK_E;
            end
            S_R_LAST: begin
                o_cmd.act = ACT_LAST_RD;
                n_state   = S_R_MV;
            end
            S_R_MV: begin
                o_cmd.act = ACT_MOVE_WR;
                n_state   = S_LEAVE2;
            end
            S_LEAVE2: n_state = i_stat.from_is_coord ? S_SE : S_CHK_E;
            S_SE: begin
                if (i_stat.electing) begin
                    n_state = r_after;
                end else begin
                    o_cmd.act = ACT_SE_BEGIN;
                    n_state   = S_SE_RD;
                end
            end
            S_SE_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.act = ACT_SCAN_RD;
                    n_state   = S_SE_EV;
                end else begin
                    o_cmd.act = ACT_SE_END;
                    n_state   = i_stat.any ? r_after : S_WIN;
                end
            end
            S_SE_EV: begin
                o_cmd.act = ACT_SE_EMIT;
                n_state   = S_SE_RD;
            end
            S_WIN: begin
                o_cmd.act = ACT_WIN;
                n_state   = S_P_RD;
            end
            S_P_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.act = ACT_SCAN_RD;
                    n_state   = S_P_EV;
                end else begin
                    o_cmd.act = ACT_IDX0;
                    n_state   = S_A_RD;
                end
            end
            S_P_EV: begin
                o_cmd.act = ACT_PRUNE;
                n_state   = i_stat.rd_lt_my ? S_P_LAST : S_P_RD;
            end
            S_P_LAST: begin
                o_cmd.act = ACT_LAST_RD;
                n_state   = S_P_MV;
            end
            S_P_MV: begin
                o_cmd.act = ACT_MOVE_WR;
                n_state   = S_P_RD;
            end
            S_A_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.act = ACT_SCAN_RD;
                    n_state   = S_A_EV;
                end else begin
                    n_state = r_after;
                end
            end
            S_A_EV: begin
                o_cmd.act = ACT_ANN;
                n_state   = S_A_RD;
            end
            S_CHK_E: begin
                n_state = S_CHK_A;
                if (i_stat.electing && i_stat.ed_reached) begin
                    n_after = S_CHK_A;
                    n_state = S_WIN;
                end
            end
            S_CHK_A: begin
                n_state = S_CHK_P;
                if (!i_stat.coord_alive && i_stat.ad_reached) begin
                    n_after = S_CHK_P;
                    n_state = S_SE;
                end
            end
            S_CHK_P: begin
                o_cmd.act = ACT_PROBE;
                n_state   = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.act = ACT_FLUSH;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_CHK_E;
            r_mode  <= MODE_WEL;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_mode  <= n_mode;
        end
    end

    assign busy = r_state != S_IDLE;
endmodule
